// ===== rtl/pinhole_reprojection_residual_top_assert.svh =====
// Assertion macros for the reprojection residual block.
// Each macro samples on i_clk; the first two are held off while i_rst_n is low.
`ifndef PINHOLE_REPROJECTION_RESIDUAL_TOP_ASSERT_SVH
`define PINHOLE_REPROJECTION_RESIDUAL_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle check that stays active while reset is applied.
`define PRR_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prr_pkg.sv =====
`default_nettype none

package prr_pkg;

    localparam int QUOT_W = 32;
    localparam int DEN_W  = 31;
    localparam int NUM_W  = 48;
    localparam int DIV_LAT = QUOT_W + 2;
    localparam int J_STAGES = 7;
    localparam int BACK_STAGES = DIV_LAT + J_STAGES;
    localparam int FRONT_STAGES = 5;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [30:0] FOCAL_X_RST  = 31'd33554432;
    localparam logic [30:0] FOCAL_Y_RST  = 31'd33554432;
    localparam logic [30:0] CENTER_X_RST = 31'd20971520;
    localparam logic [30:0] CENTER_Y_RST = 31'd15728640;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CFG_FOCAL_X  = 2'd0,
        CFG_FOCAL_Y  = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [30:0] focal_x;
        logic [30:0] focal_y;
        logic [30:0] center_x;
        logic [30:0] center_y;
    } t_cfg;

    // Input item, quat_w in the lowest bits.
    typedef struct packed {
        logic signed [31:0] meas_v;
        logic signed [31:0] meas_u;
        logic signed [31:0] point_z;
        logic signed [31:0] point_y;
        logic signed [31:0] point_x;
        logic signed [31:0] trans_z;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_x;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_w;
    } t_obs;

    // Camera-frame point with the rotation matrix (row major, Q2.30).
    typedef struct packed {
        logic               bad;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [8:0][31:0]   rot;
        logic signed [31:0] meas_u;
        logic signed [31:0] meas_v;
    } t_cam;

    typedef struct packed {
        logic               bad;
        logic [8:0][31:0]   rot;
        logic signed [31:0] meas_u;
        logic signed [31:0] meas_v;
    } t_side;

    // One result row, residual in the lowest bits.
    typedef struct packed {
        logic [2:0][31:0] pt;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] rot;
        logic [31:0]      residual;
    } t_row;

    typedef struct packed {
        logic bad;
        t_row v;
        t_row u;
    } t_item;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'(S32_MAX)) return S32_MAX;
        else if (v < 64'(S32_MIN)) return S32_MIN;
        else return $signed(v[31:0]);
    endfunction

    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [63:0] prod);
        return sat32(rnd16(prod));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pinhole_reprojection_residual_top.sv =====
// Path: an observation passes the front pipeline, the queue and the back pipeline, whose
// 32-stage divider lanes make up most of its depth; the v row is offered once the u row is taken.
// Flow: each observation takes two result transfers on the output port, which bound the rate;
// the front end keeps taking observations into a 4-entry queue while the output port is busy.
// Reset (synchronous, active low) empties the pipelines and queue and restores the
// default intrinsics; no clearing pass is needed.
`default_nettype none
`include "pinhole_reprojection_residual_top_assert.svh"

module pinhole_reprojection_residual_top
    import prr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z,
    // point_x, point_y, point_z, meas_u, meas_v
    input  wire logic [383:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // residual, jac_rot_a, jac_rot_b, jac_rot_c, jac_pos_a, jac_pos_b, jac_pos_c,
    // jac_pt_a, jac_pt_b, jac_pt_c
    output logic [319:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    // depth_invalid
    output logic              m_axis_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    t_cfg  r_cfg;
    t_obs  w_obs;
    t_cam  w_front_cam;
    t_cam  w_queue_cam;
    logic  w_push, w_full, w_pop, w_avail;
    logic  w_back_valid, w_load_ok;
    t_item w_item;

    logic  r_ov;
    logic  r_orow;
    t_item r_oitem;

    assign w_obs       = s_axis_tdata;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= FOCAL_X_RST;
            r_cfg.focal_y  <= FOCAL_Y_RST;
            r_cfg.center_x <= CENTER_X_RST;
            r_cfg.center_y <= CENTER_Y_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FOCAL_X:  r_cfg.focal_x  <= i_cfg_data[30:0];
                CFG_FOCAL_Y:  r_cfg.focal_y  <= i_cfg_data[30:0];
                CFG_CENTER_X: r_cfg.center_x <= i_cfg_data[30:0];
                CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data[30:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    prr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_obs),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_cam   (w_front_cam)
    );

    prr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cam),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_data  (w_queue_cam)
    );

    prr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_avail (w_avail),
        .o_pop   (w_pop),
        .i_cam   (w_queue_cam),
        .o_valid (w_back_valid),
        .i_ready (w_load_ok),
        .o_item  (w_item)
    );

    // The result buffer holds one observation and is free again once its v row is transferred.
    assign w_load_ok = !r_ov || (m_axis_tready && r_orow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_orow <= 1'b0;
        end else if (w_back_valid && w_load_ok) begin
            r_ov   <= 1'b1;
            r_orow <= 1'b0;
        end else if (r_ov && m_axis_tready) begin
            if (r_orow) r_ov <= 1'b0;
            else r_orow <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_back_valid && w_load_ok) r_oitem <= w_item;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_orow;
    assign m_axis_tuser  = r_oitem.bad;
    assign m_axis_tdata  = r_orow ? r_oitem.v : r_oitem.u;

    `PRR_ASSERT_NEXT(a_row_pair, (m_axis_tvalid && m_axis_tready && !m_axis_tlast), (m_axis_tvalid && m_axis_tlast && $stable(m_axis_tuser)), "v row did not follow the u row of the same observation")
    `PRR_ASSERT_NOW(a_no_overwrite, (w_back_valid && w_load_ok), (!r_ov || r_orow), "result buffer reloaded before its v row was transferred")
    `PRR_ASSERT_RESET(a_reset_idle, (!i_rst_n), (!m_axis_tvalid), "result offered straight after reset")

endmodule

`default_nettype wire

// ===== rtl/prr_front.sv =====
`default_nettype none

module prr_front
    import prr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_obs i_item,
    output logic      o_push,
    input  wire logic i_full,
    output t_cam      o_cam
);

    localparam int XX = 0, YY = 1, ZZ = 2, XY = 3, XZ = 4, YZ = 5, WX = 6, WY = 7, WZ = 8;

    logic [FRONT_STAGES-1:0] r_fv;
    logic                    w_en;

    t_obs               r_obs [FRONT_STAGES-1];
    logic signed [63:0] r_qp  [9];
    logic signed [34:0] r_qr  [9];
    logic signed [31:0] r_rot3 [9];
    logic signed [31:0] r_rot4 [9];
    logic signed [63:0] r_rp  [9];
    logic signed [31:0] w_c   [3];
    logic               w_bad;
    t_cam               r_cam;

    assign w_en    = !r_fv[FRONT_STAGES-1] || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_fv[FRONT_STAGES-1] && !i_full;
    assign o_cam   = r_cam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c[i] = sat32(64'(i == 0 ? r_obs[3].trans_x :
                               i == 1 ? r_obs[3].trans_y : r_obs[3].trans_z)
                           + rnd30(r_rp[3*i]) + rnd30(r_rp[3*i+1]) + rnd30(r_rp[3*i+2]));
        end
        w_bad = w_c[2][31] || (w_c[2] == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_obs[0] <= i_item;
            for (int k = 1; k < FRONT_STAGES-1; k++) r_obs[k] <= r_obs[k-1];

            // quaternion products, Q2.30 squared
            r_qp[XX] <= i_item.quat_x * i_item.quat_x;
            r_qp[YY] <= i_item.quat_y * i_item.quat_y;
            r_qp[ZZ] <= i_item.quat_z * i_item.quat_z;
            r_qp[XY] <= i_item.quat_x * i_item.quat_y;
            r_qp[XZ] <= i_item.quat_x * i_item.quat_z;
            r_qp[YZ] <= i_item.quat_y * i_item.quat_z;
            r_qp[WX] <= i_item.quat_w * i_item.quat_x;
            r_qp[WY] <= i_item.quat_w * i_item.quat_y;
            r_qp[WZ] <= i_item.quat_w * i_item.quat_z;

            for (int k = 0; k < 9; k++) r_qr[k] <= 35'(rnd30(r_qp[k]));

            r_rot3[0] <= sat32(64'sd1073741824 - 64'sd2 * (64'(r_qr[YY]) + 64'(r_qr[ZZ])));
            r_rot3[1] <= sat32(64'sd2 * (64'(r_qr[XY]) - 64'(r_qr[WZ])));
            r_rot3[2] <= sat32(64'sd2 * (64'(r_qr[XZ]) + 64'(r_qr[WY])));
            r_rot3[3] <= sat32(64'sd2 * (64'(r_qr[XY]) + 64'(r_qr[WZ])));
            r_rot3[4] <= sat32(64'sd1073741824 - 64'sd2 * (64'(r_qr[XX]) + 64'(r_qr[ZZ])));
            r_rot3[5] <= sat32(64'sd2 * (64'(r_qr[YZ]) - 64'(r_qr[WX])));
            r_rot3[6] <= sat32(64'sd2 * (64'(r_qr[XZ]) - 64'(r_qr[WY])));
            r_rot3[7] <= sat32(64'sd2 * (64'(r_qr[YZ]) + 64'(r_qr[WX])));
            r_rot3[8] <= sat32(64'sd1073741824 - 64'sd2 * (64'(r_qr[XX]) + 64'(r_qr[YY])));

            for (int i = 0; i < 3; i++) begin
                r_rp[3*i]   <= r_rot3[3*i]   * r_obs[2].point_x;
                r_rp[3*i+1] <= r_rot3[3*i+1] * r_obs[2].point_y;
                r_rp[3*i+2] <= r_rot3[3*i+2] * r_obs[2].point_z;
            end
            for (int k = 0; k < 9; k++) r_rot4[k] <= r_rot3[k];

            // A point on or behind the image plane is projected at a depth of one LSB.
            r_cam.bad    <= w_bad;
            r_cam.x      <= w_c[0];
            r_cam.y      <= w_c[1];
            r_cam.z      <= w_bad ? 32'sd1 : w_c[2];
            for (int k = 0; k < 9; k++) r_cam.rot[k] <= r_rot4[k];
            r_cam.meas_u <= r_obs[3].meas_u;
            r_cam.meas_v <= r_obs[3].meas_v;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prr_queue.sv =====
`default_nettype none

module prr_queue
    import prr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cam i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_avail,
    output t_cam      o_data
);

    t_cam              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

`default_nettype wire

// ===== rtl/prr_div.sv =====
`default_nettype none

module prr_div
    import prr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_neg,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic signed [31:0]    o_quot
);

    // Restoring division, one quotient bit per stage.
    logic [DEN_W-1:0]  r_rem [QUOT_W+1];
    logic [QUOT_W-1:0] r_low [QUOT_W+1];
    logic [QUOT_W-1:0] r_q   [QUOT_W+1];
    logic [DEN_W-1:0]  r_den [QUOT_W+1];
    logic              r_neg [QUOT_W+1];
    logic              r_ovf [QUOT_W+1];
    logic [DEN_W-1:0]  w_rem [QUOT_W];
    logic              w_ge  [QUOT_W];
    logic signed [31:0] w_out;
    logic signed [31:0] r_out;

    for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
        logic [DEN_W:0] w_t;
        logic [DEN_W:0] w_diff;
        always_comb begin
            w_t      = {r_rem[s], r_low[s][QUOT_W-1]};
            w_diff   = w_t - {1'b0, r_den[s]};
            w_ge[s]  = (w_t >= {1'b0, r_den[s]});
            w_rem[s] = w_ge[s] ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
        end
    end

    always_comb begin
        if (r_neg[QUOT_W]) begin
            if (r_ovf[QUOT_W] || (r_q[QUOT_W] > 32'h8000_0000)) w_out = S32_MIN;
            else w_out = $signed(~r_q[QUOT_W] + 32'd1);
        end else begin
            if (r_ovf[QUOT_W] || r_q[QUOT_W][QUOT_W-1]) w_out = S32_MAX;
            else w_out = $signed(r_q[QUOT_W]);
        end
    end

    assign o_quot = r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // The quotient overflows 32 bits when the high numerator part reaches the divisor.
            r_rem[0] <= DEN_W'(i_num[NUM_W-1:QUOT_W]);
            r_ovf[0] <= (DEN_W'(i_num[NUM_W-1:QUOT_W]) >= i_den);
            r_low[0] <= i_num[QUOT_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            for (int s = 0; s < QUOT_W; s++) begin
                r_rem[s+1] <= w_rem[s];
                r_low[s+1] <= {r_low[s][QUOT_W-2:0], 1'b0};
                r_q[s+1]   <= {r_q[s][QUOT_W-2:0], w_ge[s]};
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
            r_out <= w_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prr_back.sv =====
`default_nettype none

module prr_back
    import prr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_avail,
    output logic       o_pop,
    input  wire t_cam  i_cam,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_item      o_item
);

    localparam int SIDE_LEN = BACK_STAGES - 1;
    localparam logic [NUM_W-1:0] IZ_NUM = NUM_W'(1) << QUOT_W;

    logic [BACK_STAGES-1:0] r_bv;
    logic                   w_en;
    t_side                  r_side [SIDE_LEN];

    logic signed [31:0] w_fx, w_fy, w_cx, w_cy;
    logic [31:0]        w_xmag, w_ymag;
    logic signed [31:0] w_a, w_b, w_iz;

    logic signed [63:0] r_j1_fxa, r_j1_fxb, r_j1_fya, r_j1_fyb, r_j1_fxz, r_j1_fyz;
    logic signed [31:0] r_j1_a, r_j1_b, r_j1_iz;
    logic signed [31:0] r_j2_fa, r_j2_fb, r_j2_fya, r_j2_fyb, r_j2_fxz, r_j2_fyz;
    logic signed [31:0] r_j2_a, r_j2_b, r_j2_iz;
    logic signed [63:0] r_j3_fab, r_j3_faa, r_j3_faz, r_j3_fybb, r_j3_fyab, r_j3_fybz;
    logic signed [31:0] r_j3_fb, r_j3_fya, r_j3_fxz, r_j3_fyz, r_j3_res_u, r_j3_res_v;
    logic signed [31:0] r_j4_fab, r_j4_faa, r_j4_faz, r_j4_fybb, r_j4_fyab, r_j4_fybz;
    logic signed [31:0] r_j4_fb, r_j4_fya, r_j4_fxz, r_j4_fyz, r_j4_res_u, r_j4_res_v;
    t_row               r_j5_u, r_j5_v;
    t_row               r_j6_u, r_j6_v;
    logic signed [63:0] r_j6_u0 [3];
    logic signed [63:0] r_j6_u2 [3];
    logic signed [63:0] r_j6_v1 [3];
    logic signed [63:0] r_j6_v2 [3];
    t_item              r_j7;

    assign w_en    = !r_bv[BACK_STAGES-1] || i_ready;
    assign o_pop   = w_en && i_avail;
    assign o_valid = r_bv[BACK_STAGES-1];
    assign o_item  = r_j7;

    assign w_fx = $signed({1'b0, i_cfg.focal_x});
    assign w_fy = $signed({1'b0, i_cfg.focal_y});
    assign w_cx = $signed({1'b0, i_cfg.center_x});
    assign w_cy = $signed({1'b0, i_cfg.center_y});

    assign w_xmag = i_cam.x[31] ? (~i_cam.x + 32'd1) : i_cam.x;
    assign w_ymag = i_cam.y[31] ? (~i_cam.y + 32'd1) : i_cam.y;

    prr_div u_div_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_neg  (i_cam.x[31]),
        .i_num  ({w_xmag, 16'b0}),
        .i_den  (i_cam.z[DEN_W-1:0]),
        .o_quot (w_a)
    );

    prr_div u_div_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_neg  (i_cam.y[31]),
        .i_num  ({w_ymag, 16'b0}),
        .i_den  (i_cam.z[DEN_W-1:0]),
        .o_quot (w_b)
    );

    prr_div u_div_iz (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_neg  (1'b0),
        .i_num  (IZ_NUM),
        .i_den  (i_cam.z[DEN_W-1:0]),
        .o_quot (w_iz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[BACK_STAGES-2:0], i_avail};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0].bad    <= i_cam.bad;
            r_side[0].rot    <= i_cam.rot;
            r_side[0].meas_u <= i_cam.meas_u;
            r_side[0].meas_v <= i_cam.meas_v;
            for (int k = 1; k < SIDE_LEN; k++) r_side[k] <= r_side[k-1];

            r_j1_fxa <= w_fx * w_a;
            r_j1_fxb <= w_fx * w_b;
            r_j1_fya <= w_fy * w_a;
            r_j1_fyb <= w_fy * w_b;
            r_j1_fxz <= w_fx * w_iz;
            r_j1_fyz <= w_fy * w_iz;
            r_j1_a   <= w_a;
            r_j1_b   <= w_b;
            r_j1_iz  <= w_iz;

            r_j2_fa  <= mulq(r_j1_fxa);
            r_j2_fb  <= mulq(r_j1_fxb);
            r_j2_fya <= mulq(r_j1_fya);
            r_j2_fyb <= mulq(r_j1_fyb);
            r_j2_fxz <= mulq(r_j1_fxz);
            r_j2_fyz <= mulq(r_j1_fyz);
            r_j2_a   <= r_j1_a;
            r_j2_b   <= r_j1_b;
            r_j2_iz  <= r_j1_iz;

            r_j3_fab   <= r_j2_fa * r_j2_b;
            r_j3_faa   <= r_j2_fa * r_j2_a;
            r_j3_faz   <= r_j2_fa * r_j2_iz;
            r_j3_fybb  <= r_j2_fyb * r_j2_b;
            r_j3_fyab  <= r_j2_fya * r_j2_b;
            r_j3_fybz  <= r_j2_fyb * r_j2_iz;
            r_j3_fb    <= r_j2_fb;
            r_j3_fya   <= r_j2_fya;
            r_j3_fxz   <= r_j2_fxz;
            r_j3_fyz   <= r_j2_fyz;
            r_j3_res_u <= sat32(64'(r_side[DIV_LAT+1].meas_u) - (64'(r_j2_fa) + 64'(w_cx)));
            r_j3_res_v <= sat32(64'(r_side[DIV_LAT+1].meas_v) - (64'(r_j2_fyb) + 64'(w_cy)));

            r_j4_fab   <= mulq(r_j3_fab);
            r_j4_faa   <= mulq(r_j3_faa);
            r_j4_faz   <= mulq(r_j3_faz);
            r_j4_fybb  <= mulq(r_j3_fybb);
            r_j4_fyab  <= mulq(r_j3_fyab);
            r_j4_fybz  <= mulq(r_j3_fybz);
            r_j4_fb    <= r_j3_fb;
            r_j4_fya   <= r_j3_fya;
            r_j4_fxz   <= r_j3_fxz;
            r_j4_fyz   <= r_j3_fyz;
            r_j4_res_u <= r_j3_res_u;
            r_j4_res_v <= r_j3_res_v;

            r_j5_u.residual <= r_j4_res_u;
            r_j5_u.rot[0]   <= r_j4_fab;
            r_j5_u.rot[1]   <= sat32(-64'(w_fx) - 64'(r_j4_faa));
            r_j5_u.rot[2]   <= r_j4_fb;
            r_j5_u.pos[0]   <= sat32(-64'(r_j4_fxz));
            r_j5_u.pos[1]   <= '0;
            r_j5_u.pos[2]   <= r_j4_faz;
            r_j5_u.pt       <= '0;
            r_j5_v.residual <= r_j4_res_v;
            r_j5_v.rot[0]   <= sat32(64'(w_fy) + 64'(r_j4_fybb));
            r_j5_v.rot[1]   <= sat32(-64'(r_j4_fyab));
            r_j5_v.rot[2]   <= sat32(-64'(r_j4_fya));
            r_j5_v.pos[0]   <= '0;
            r_j5_v.pos[1]   <= sat32(-64'(r_j4_fyz));
            r_j5_v.pos[2]   <= r_j4_fybz;
            r_j5_v.pt       <= '0;

            // Only the non-zero translation entries of each row take part in K'*R.
            for (int j = 0; j < 3; j++) begin
                r_j6_u0[j] <= $signed(r_j5_u.pos[0]) * $signed(r_side[DIV_LAT+4].rot[j]);
                r_j6_u2[j] <= $signed(r_j5_u.pos[2]) * $signed(r_side[DIV_LAT+4].rot[6+j]);
                r_j6_v1[j] <= $signed(r_j5_v.pos[1]) * $signed(r_side[DIV_LAT+4].rot[3+j]);
                r_j6_v2[j] <= $signed(r_j5_v.pos[2]) * $signed(r_side[DIV_LAT+4].rot[6+j]);
            end
            r_j6_u <= r_j5_u;
            r_j6_v <= r_j5_v;

            r_j7.bad <= r_side[DIV_LAT+5].bad;
            r_j7.u.residual <= r_j6_u.residual;
            r_j7.u.rot      <= r_j6_u.rot;
            r_j7.u.pos      <= r_j6_u.pos;
            r_j7.v.residual <= r_j6_v.residual;
            r_j7.v.rot      <= r_j6_v.rot;
            r_j7.v.pos      <= r_j6_v.pos;
            for (int j = 0; j < 3; j++) begin
                r_j7.u.pt[j] <= sat32(rnd30(r_j6_u0[j]) + rnd30(r_j6_u2[j]));
                r_j7.v.pt[j] <= sat32(rnd30(r_j6_v1[j]) + rnd30(r_j6_v2[j]));
            end
        end
    end

endmodule

`default_nettype wire
